// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int OCC_W    = 9;
   localparam int STATUS_W = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } spq_entry_type;

   typedef struct packed {
      logic                ins;
      logic                rem;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } spq_cmd_type;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds a pair, shifts on insert and remove.
module spq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::spq_cmd_type   cmd,
   input  spq_pkg::spq_entry_type left_entry,
   input  logic                   left_gt,
   input  spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type cur_entry,
   output logic                   cur_gt
);
   import spq_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [KEY_W-1:0]    key_ff;
   logic [KEY_W-1:0]    key_in;
   logic [HANDLE_W-1:0] handle_ff;
   logic [HANDLE_W-1:0] handle_in;
   logic                take;

   // strictly greater: equal keys keep arrival order
   assign cur_gt = valid_ff && (key_ff > cmd.key);
   assign take   = cur_gt || (!valid_ff && left_entry.valid);

   assign cur_entry.valid  = valid_ff;
   assign cur_entry.key    = key_ff;
   assign cur_entry.handle = handle_ff;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      if (cmd.rem) begin
         valid_in  = right_entry.valid;
         key_in    = right_entry.key;
         handle_in = right_entry.handle;
      end else if (cmd.ins && take) begin
         valid_in = 1'b1;
         if (left_gt) begin
            key_in    = left_entry.key;
            handle_in = left_entry.handle;
         end else begin
            key_in    = cmd.key;
            handle_in = cmd.handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue built from a chain of cells.
//
// Usage:
//   Requests arrive on req_ (func, new_key, new_handle). Insert puts the pair
//   behind every stored pair with a key not greater, so equal keys leave in
//   arrival order. Remove returns the pair with the smallest key.
//   Each request gives one response on rsp_: status, out_key, out_handle and
//   occupancy after the operation. A full queue rejects inserts; a remove on
//   an empty queue returns status empty with zero key and handle.
// Timing:
//   Every cell compares its key with the request in parallel and shifts in
//   the same cycle: one request per clock while req_stall is low, response
//   registered in the cycle after acceptance.
// Reset:
//   Synchronous reset clears all cell valid bits, the count and the response
//   valid bit; the queue is empty and ready in the next cycle.
// Stall:
//   The response register holds while rsp_stall is high; req_stall is raised
//   only while a response is held and stalled, so no request is lost.
module sorted_priority_queue #(
   parameter int DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [spq_pkg::KEY_W-1:0]      req_new_key,
   input  logic [spq_pkg::HANDLE_W-1:0]   req_new_handle,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spq_pkg::KEY_W-1:0]      rsp_out_key,
   output logic [spq_pkg::HANDLE_W-1:0]   rsp_out_handle,
   output logic [spq_pkg::OCC_W-1:0]      rsp_occupancy
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   spq_entry_type       chain [DEPTH];
   logic [DEPTH-1:0]    gt;
   spq_cmd_type         cmd;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [KEY_W-1:0]    okey_ff;
   logic [KEY_W-1:0]    okey_in;
   logic [HANDLE_W-1:0] ohandle_ff;
   logic [HANDLE_W-1:0] ohandle_in;
   logic [OCC_W-1:0]    occ_ff;
   logic [OCC_W-1:0]    occ_in;

   logic accept;
   logic full;
   logic empty;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = chain[DEPTH-1].valid;
   assign empty     = !chain[0].valid;

   assign cmd.ins    = accept && (req_func == FUNC_INSERT) && !full;
   assign cmd.rem    = accept && (req_func == FUNC_REMOVE) && !empty;
   assign cmd.key    = req_new_key;
   assign cmd.handle = req_new_handle;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_entry_type left_e;
      spq_entry_type right_e;
      logic          left_g;

      if (i == 0) begin : g_head
         assign left_e = '{valid: 1'b1, key: '0, handle: '0};
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = chain[i-1];
         assign left_g = gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_e = '{valid: 1'b0, key: '0, handle: '0};
      end else begin : g_body
         assign right_e = chain[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_gt     (left_g),
         .right_entry (right_e),
         .cur_entry   (chain[i]),
         .cur_gt      (gt[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      okey_in      = okey_ff;
      ohandle_in   = ohandle_ff;
      occ_in       = occ_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.rem) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         okey_in      = '0;
         ohandle_in   = '0;
         if (req_func == FUNC_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end
         end else if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            okey_in    = chain[0].key;
            ohandle_in = chain[0].handle;
         end
         occ_in = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      okey_ff    <= okey_in;
      ohandle_ff <= ohandle_in;
      occ_ff     <= occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_key    = okey_ff;
   assign rsp_out_handle = ohandle_ff;
   assign rsp_occupancy  = occ_ff;

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == !chain[0].valid)
      else $error("head valid bit disagrees with count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH)) == chain[DEPTH-1].valid)
      else $error("tail valid bit disagrees with count");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      chain[1].valid |-> (chain[0].valid && (chain[0].key <= chain[1].key)))
      else $error("head pair out of order");

endmodule
